// ===== src/mtsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mtsa_pkg: shared types, constants and helpers for the macro-tiled address
// generator. Element format codes, register indexes and the micro tile
// pixel interleave.
// ----------------------------------------------------------------------------
package mtsa_pkg;

  // Coordinate width default (range 5 to 16)
  localparam int unsigned COORD_WIDTH_DEF = 13;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOCK_FORMAT = 2'd0,
    REG_ROW_PITCH    = 2'd1,
    REG_SWIZZLE_WORD = 2'd2
  } reg_index_t;

  // Element size codes; the unused code behaves as a 32-bit element
  typedef enum logic [1:0] {
    FMT_128 = 2'd0,
    FMT_64  = 2'd1,
    FMT_32  = 2'd2
  } fmt_t;

  localparam int unsigned PITCH_W      = 14;
  localparam int unsigned TILE_SHIFT   = 5;   // macro tile is 32 elements wide
  localparam int unsigned PITCH_TILE_W = PITCH_W - TILE_SHIFT;
  localparam int unsigned ROW_SHIFT    = 4;   // macro tile is 16 rows high
  localparam int unsigned MICRO_W      = 6;   // pixel index within 8x8 micro tile
  localparam int unsigned BP_W         = 3;   // bank and pipe bits
  localparam int unsigned SWZ_LSB      = 8;
  localparam int unsigned OFFSET_W     = 32;
  localparam int unsigned LOW_BYTE_W   = 8;

  // Registered configuration as seen by the datapath
  typedef struct packed {
    logic [1:0]              format;
    logic [PITCH_TILE_W-1:0] pitch_tiles;
    logic [BP_W-1:0]         swizzle;
  } cfg_t;

  // Pixel index inside the micro tile; x and y are the low three bits
  function automatic logic [MICRO_W-1:0] micro_index(input logic [1:0] format,
                                                     input logic [2:0] x,
                                                     input logic [2:0] y);
    logic [MICRO_W-1:0] idx;
    unique case (format)
      FMT_128: idx = {y[2:1], x[2:0], y[0]};
      FMT_64:  idx = {y[2:1], x[2:1], y[0], x[0]};
      default: idx = {y[2:1], x[2], y[0], x[1:0]};
    endcase
    return idx;
  endfunction

endpackage

// ===== src/macro_tiled_surface_address.sv =====
// ----------------------------------------------------------------------------
// macro_tiled_surface_address: 2D macro-tiled surface byte offset
// Maps an element coordinate (x, y) to its byte offset in a thin macro-tiled
// surface, with pipe/bank swizzle placed at offset bits 8 to 10.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   s_*      | in  | s_tvalid/s_tready  | s_tdata: coord_x, coord_y
//   m_*      | out | m_tvalid/m_tready  | m_tdata: byte_offset
//   cfg_*    | in  | cfg_wr_en          | cfg_index, cfg_data
//
// One item per cycle sustained while m_tready allows; the item passes three
// registers (input, tile index multiply, offset), and m_tvalid rises once it
// reaches the offset register. The multiply of pitch-in-tiles by tile row
// sets the middle stage. A stall on m_tready freezes all three stages at
// once; s_tready is high whenever the output register is empty or being
// taken.
// Reset clears the valid bits and loads the register defaults (32-bit
// elements, zero pitch, zero swizzle).
// ----------------------------------------------------------------------------
module macro_tiled_surface_address import mtsa_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [COORD_WIDTH-1:0] coord_x, [2*COORD_WIDTH-1:COORD_WIDTH] coord_y, zero pad
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] byte_offset
  output logic [OFFSET_W-1:0]           m_tdata,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cfg_t cfg;
  logic adv;
  logic v1;
  logic v2;

  // Configuration registers; only format bits 1:0, pitch/32 (bits 13 to 5) and swizzle bits 8 to 10 matter
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format      <= FMT_32;
      cfg.pitch_tiles <= '0;
      cfg.swizzle     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BLOCK_FORMAT: cfg.format      <= cfg_data[1:0];
        REG_ROW_PITCH:    cfg.pitch_tiles <= cfg_data[PITCH_W-1:TILE_SHIFT];
        REG_SWIZZLE_WORD: cfg.swizzle     <= cfg_data[SWZ_LSB+BP_W-1:SWZ_LSB];
        default: ;  // no register at this index: drop the write
      endcase
    end
  end

  // Advance the whole pipe unless a finished item is held at the output
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= s_tvalid;
      v2       <= v1;
      m_tvalid <= v2;
    end
  end

  mtsa_datapath #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .adv        (adv),
    .cfg        (cfg),
    .coord_x    (s_tdata[COORD_WIDTH-1:0]),
    .coord_y    (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .byte_offset(m_tdata)
  );

endmodule

// ===== src/mtsa_datapath.sv =====
// ----------------------------------------------------------------------------
// mtsa_datapath: three-register address pipeline
// Input register, tile index / micro index register, offset register.
// All registers advance together on adv.
// ----------------------------------------------------------------------------
module mtsa_datapath import mtsa_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   adv,
  input  cfg_t                   cfg,
  input  logic [COORD_WIDTH-1:0] coord_x,
  input  logic [COORD_WIDTH-1:0] coord_y,
  output logic [OFFSET_W-1:0]    byte_offset
);

  localparam int unsigned TX_W   = (COORD_WIDTH > TILE_SHIFT) ? COORD_WIDTH - TILE_SHIFT : 1;
  localparam int unsigned TY_W   = COORD_WIDTH - ROW_SHIFT;
  localparam int unsigned PROD_W = PITCH_TILE_W + TY_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned WIDE_W = 16;

  // stage 1: captured coordinates
  logic [COORD_WIDTH-1:0] x_q;
  logic [COORD_WIDTH-1:0] y_q;

  // stage 2: tile number, micro index, bank-pipe bits
  logic [SUM_W-1:0]   tile_num;
  logic [MICRO_W-1:0] micro;
  logic [BP_W-1:0]    bank_pipe;

  logic [WIDE_W-1:0]  xw;
  logic [WIDE_W-1:0]  yw;
  logic [TX_W-1:0]    tile_col;
  logic [TY_W-1:0]    tile_row;
  logic [SUM_W-1:0]   tile_num_next;
  logic [BP_W-1:0]    bank_pipe_next;

  logic [OFFSET_W-1:0] tile_part;
  logic [OFFSET_W-1:0] micro_part;
  logic [OFFSET_W-1:0] lin;
  logic [OFFSET_W-1:0] byte_offset_next;

  always_comb begin
    xw       = WIDE_W'(x_q);
    yw       = WIDE_W'(y_q);
    tile_col = TX_W'(x_q >> TILE_SHIFT);
    tile_row = TY_W'(y_q >> ROW_SHIFT);
    tile_num_next = SUM_W'(PROD_W'(cfg.pitch_tiles) * PROD_W'(tile_row)) + SUM_W'(tile_col);
    // bank = {x4^y4, y5^x3}, pipe = x3^y3, then swizzle
    bank_pipe_next = {xw[4] ^ yw[4], yw[5] ^ xw[3], xw[3] ^ yw[3]} ^ cfg.swizzle;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_q       <= coord_x;
      y_q       <= coord_y;
      tile_num  <= tile_num_next;
      micro     <= micro_index(cfg.format, xw[2:0], yw[2:0]);
      bank_pipe <= bank_pipe_next;
    end
  end

  // Linear address: tile number times an eighth of the tile bytes plus element offset
  always_comb begin
    unique case (cfg.format)
      FMT_128: begin
        tile_part  = OFFSET_W'(tile_num) << 10;
        micro_part = OFFSET_W'(micro) << 4;
      end
      FMT_64: begin
        tile_part  = OFFSET_W'(tile_num) << 9;
        micro_part = OFFSET_W'(micro) << 3;
      end
      default: begin
        tile_part  = OFFSET_W'(tile_num) << 8;
        micro_part = OFFSET_W'(micro) << 2;
      end
    endcase
    lin = tile_part + micro_part;
    // open a gap at bits 8 to 10 for the bank-pipe bits
    byte_offset_next = {lin[OFFSET_W-BP_W-1:LOW_BYTE_W], bank_pipe, lin[LOW_BYTE_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_offset <= byte_offset_next;
    end
  end

endmodule

// ===== src/mtsa_checker.sv =====
// ----------------------------------------------------------------------------
// mtsa_checker: port-level checks for macro_tiled_surface_address
// Watches the stream ports; bound to the top level.
// ----------------------------------------------------------------------------
module mtsa_checker import mtsa_pkg::*; (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [OFFSET_W-1:0]                m_tdata
);

  // A held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // Input side is ready exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // An accepted item shows up once the pipe has advanced it through the middle and output registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 s_tready ##1 s_tready |=> m_tvalid)
    else $error("accepted item lost in pipeline");

endmodule

bind macro_tiled_surface_address mtsa_checker u_mtsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== test/macro_tiled_surface_address_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// macro_tiled_surface_address_tb: self-checking bench for the tiled address
// generator. A table of directed coordinates runs first: reset defaults, the
// coordinate and pitch extremes, every element format, the spare format code,
// the doubled pipe bit and wide register writes. Random register settings and
// coordinates follow. Each offset is checked against a table answer or a local
// predictor, with random output stalls and input gaps outside the last phase.
// ----------------------------------------------------------------------------
module macro_tiled_surface_address_tb;
  import mtsa_pkg::*;

  localparam int unsigned CW          = COORD_WIDTH_DEF;
  localparam int unsigned TDATA_W     = ((2 * CW + 7) / 8) * 8;
  localparam int unsigned CMAX        = (1 << CW) - 1;
  localparam int          CYCLE_LIMIT = 200_000;
  localparam int          SETTLE      = 8;     // extra wait past the 3-stage pipeline
  localparam int          NUM_PHASES  = 9;
  localparam int          PHASE_ITEMS = 100;
  localparam int          NUM_ROWS    = 22;

  // Index with no register behind it, and the format code left unused
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [1:0]             FMT_SPARE = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OFFSET_W-1:0]   m_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always #6 clk = ~clk;

  macro_tiled_surface_address #(.COORD_WIDTH(CW)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // One pending offset, with the coordinate that caused it for messages
  typedef struct packed {
    logic [CW-1:0]       x;
    logic [CW-1:0]       y;
    logic [OFFSET_W-1:0] offset;
  } pending_offset_t;

  // Directed row: raw register words, coordinate, and an optional typed answer
  typedef struct packed {
    logic [31:0]         fmt_raw;
    logic [31:0]         pitch_raw;
    logic [31:0]         swz_raw;
    logic [CW-1:0]       x;
    logic [CW-1:0]       y;
    logic                known;
    logic [OFFSET_W-1:0] offset;
  } coord_row_t;

  pending_offset_t pending_offsets[$];

  // Shadow of the block's registers, as written; the predictor picks out the bits used
  logic [1:0]         cur_fmt   = FMT_32;
  logic [PITCH_W-1:0] cur_pitch = '0;
  logic [31:0]        cur_swz   = '0;

  int  error_count    = 0;
  int  checked_count  = 0;
  int  directed_count = 0;
  int  random_count   = 0;
  int  setting_count  = 1;
  int  cycle_count    = 0;
  int  run_left       = 0;
  int  hold_count     = 0;
  logic quiet         = 1'b0;
  pending_offset_t head;

  // Rows from the reset defaults come first, before any register write.
  coord_row_t coord_rows [NUM_ROWS] = '{
    '{32'(FMT_32), 32'd0, 32'd0, 13'd0, 13'd0, 1'b1, 32'h0000_0000},
    '{32'(FMT_32), 32'd0, 32'd0, 13'd1, 13'd0, 1'b1, 32'h0000_0004},
    // pipe and low bank bit set: bit 8 gets the pipe term twice
    '{32'(FMT_32), 32'd0, 32'd0, 13'd8, 13'd0, 1'b1, 32'h0000_0300},
    '{32'(FMT_32), 32'd0, 32'd0, 13'h1FFF, 13'h1FFF, 1'b0, 32'h0},
    '{32'(FMT_32), 32'd0, 32'd0, 13'd0, 13'h1FFF, 1'b0, 32'h0},
    '{32'(FMT_32), 32'd0, 32'd0, 13'h1FFF, 13'd0, 1'b0, 32'h0},
    // full bank-pipe swizzle, then every other swizzle bit set
    '{32'(FMT_32), 32'd0, 32'h0000_0700, 13'd0, 13'd0, 1'b1, 32'h0000_0700},
    '{32'(FMT_32), 32'd0, 32'hFFFF_F8FF, 13'd0, 13'd0, 1'b1, 32'h0000_0000},
    '{32'(FMT_32), 32'd0, 32'hFFFF_F8FF, 13'h1FFF, 13'h1FFF, 1'b0, 32'h0},
    '{32'(FMT_128), 32'd8192, 32'd0, 13'd0, 13'd0, 1'b1, 32'h0000_0000},
    '{32'(FMT_128), 32'd8192, 32'd0, 13'h1FFF, 13'h1FFF, 1'b0, 32'h0},
    '{32'(FMT_128), 32'd8192, 32'd0, 13'd37, 13'd21, 1'b0, 32'h0},
    '{32'(FMT_64), 32'd8192, 32'd0, 13'h1FFF, 13'h1FFF, 1'b0, 32'h0},
    '{32'(FMT_64), 32'd8192, 32'd0, 13'd5, 13'd3, 1'b0, 32'h0},
    // spare format code runs as a 32-bit element
    '{32'(FMT_SPARE), 32'd8192, 32'd0, 13'h1FFF, 13'h1FFF, 1'b0, 32'h0},
    '{32'(FMT_SPARE), 32'd8192, 32'd0, 13'd6, 13'd5, 1'b0, 32'h0},
    // wide register words: only the low register bits survive
    '{32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF, 13'h1FFF, 1'b0, 32'h0},
    '{32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd32, 13'd16, 1'b0, 32'h0},
    '{32'(FMT_32), 32'd16383, 32'h0000_0300, 13'h1FFF, 13'h1FFF, 1'b0, 32'h0},
    '{32'(FMT_32), 32'd16383, 32'h0000_0300, 13'd31, 13'd15, 1'b0, 32'h0},
    '{32'(FMT_64), 32'd31, 32'h0000_0500, 13'd100, 13'd200, 1'b0, 32'h0},
    '{32'(FMT_128), 32'd32, 32'h0000_0600, 13'd33, 13'd17, 1'b0, 32'h0}
  };

  // Byte offset of element (x, y) for the given register contents.
  function automatic logic [OFFSET_W-1:0] tiled_offset(input logic [1:0]         fmt,
                                                       input logic [PITCH_W-1:0] pitch,
                                                       input logic [31:0]        swz,
                                                       input logic [CW-1:0]      x,
                                                       input logic [CW-1:0]      y);
    logic [63:0] xw, yw, pw, elem_bits, pix, tile_off, lin, full;
    logic [1:0]  bank;
    logic        pipe;
    logic [2:0]  bank_pipe;
    xw = 64'(x);
    yw = 64'(y);
    pw = 64'(pitch);
    case (fmt)
      FMT_128: begin
        elem_bits = 64'd128;
        pix = ((xw & 64'd7) << 1) | ((yw & 64'd6) << 3) | (yw & 64'd1);
      end
      FMT_64: begin
        elem_bits = 64'd64;
        pix = ((xw & 64'd6) << 1) | (xw & 64'd1) | ((yw & 64'd6) << 3)
            | ((yw & 64'd1) << 1);
      end
      default: begin
        elem_bits = 64'd32;
        pix = ((xw & 64'd4) << 1) | (xw & 64'd3) | ((yw & 64'd6) << 3)
            | ((yw & 64'd1) << 2);
      end
    endcase
    pipe = xw[3] ^ yw[3];
    bank = {xw[4] ^ yw[4], yw[5] ^ xw[3]};
    // pipe + 2*bank never exceeds 7, so it fits the three bank-pipe bits
    bank_pipe = {bank, pipe} ^ swz[SWZ_LSB +: BP_W];
    // macro tile holds 512 elements: elem_bits * 64 bytes
    tile_off = ((xw >> TILE_SHIFT) + (pw >> TILE_SHIFT) * (yw >> ROW_SHIFT))
             * (elem_bits * 64'd64);
    lin = (elem_bits * pix + tile_off) >> 3;
    full = (64'(bank_pipe) << SWZ_LSB) | (64'(bank_pipe[0]) << SWZ_LSB)
         | ((lin & ~64'hFF) << 3) | (lin & 64'hFF);
    return full[OFFSET_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [OFFSET_W-1:0] got,
                                 input logic [OFFSET_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // Write one register; hold the enable for one edge, then drop it for one.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_BLOCK_FORMAT: cur_fmt   = value[1:0];
      REG_ROW_PITCH:    cur_pitch = value[PITCH_W-1:0];
      REG_SWIZZLE_WORD: cur_swz   = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid and hold off until every pending offset has come back.
  task automatic drain_offsets();
    s_tvalid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Present one coordinate, wait for acceptance, queue its offset.
  task automatic send_coord(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic known, input logic [OFFSET_W-1:0] typed);
    pending_offset_t entry;
    if (!quiet && run_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      run_left = $urandom_range(0, 24);
    end else if (run_left != 0) begin
      run_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'({y, x});
    do @(posedge clk); while (!s_tready);
    entry.x = x;
    entry.y = y;
    entry.offset = known ? typed : tiled_offset(cur_fmt, cur_pitch, cur_swz, x, y);
    pending_offsets.push_back(entry);
  endtask

  function automatic logic [CW-1:0] pick_coord(input int kind, input bit extreme);
    if (extreme) return ($urandom_range(0, 1) != 0) ? CW'(CMAX) : '0;
    if (kind >= 6) return CW'($urandom_range(0, 63));
    return CW'($urandom_range(0, CMAX));
  endfunction

  // Output side: stall in random bursts, none in the quiet part.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
    end else if (m_tready) begin
      if ($urandom_range(0, 3) == 0) begin
        m_tready   <= 1'b0;
        hold_count <= $urandom_range(0, 6);
      end else begin
        hold_count <= $urandom_range(0, 20);
      end
    end else begin
      m_tready   <= 1'b1;
      hold_count <= $urandom_range(0, 20);
    end
  end

  // Compare each accepted offset with the oldest pending one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_offsets.size() == 0) begin
        report_mismatch("offset with nothing pending", m_tdata, '0);
      end else begin
        head = pending_offsets.pop_front();
        if (m_tdata !== head.offset) begin
          report_mismatch($sformatf("x=%0d y=%0d", head.x, head.y), m_tdata, head.offset);
        end
        checked_count++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d offsets pending",
               cycle_count, pending_offsets.size());
      $display("macro_tiled_surface_address regression: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] last_fmt, last_pitch, last_swz, fmt_word, pitch_word;
    int kind;
    logic [CW-1:0] cx, cy;
    last_fmt   = 32'(FMT_32);
    last_pitch = 32'd0;
    last_swz   = 32'd0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table; rewrite registers only where a row changes them.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (coord_rows[i].fmt_raw != last_fmt || coord_rows[i].pitch_raw != last_pitch
          || coord_rows[i].swz_raw != last_swz) begin
        drain_offsets();
        if (coord_rows[i].fmt_raw != last_fmt)
          write_reg(REG_BLOCK_FORMAT, coord_rows[i].fmt_raw);
        if (coord_rows[i].pitch_raw != last_pitch)
          write_reg(REG_ROW_PITCH, coord_rows[i].pitch_raw);
        if (coord_rows[i].swz_raw != last_swz)
          write_reg(REG_SWIZZLE_WORD, coord_rows[i].swz_raw);
        last_fmt   = coord_rows[i].fmt_raw;
        last_pitch = coord_rows[i].pitch_raw;
        last_swz   = coord_rows[i].swz_raw;
        setting_count++;
      end
      send_coord(coord_rows[i].x, coord_rows[i].y, coord_rows[i].known,
                 coord_rows[i].offset);
      directed_count++;
    end

    // Random phases, each with fresh register contents; the last one runs
    // with no idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_offsets();
      if (p == NUM_PHASES - 1) quiet <= 1'b1;
      fmt_word = 32'(p % 4);
      if ($urandom_range(0, 3) == 0) fmt_word = ($urandom & ~32'd3) | fmt_word;
      case ($urandom_range(0, 4))
        0:       pitch_word = 32'd0;
        1:       pitch_word = 32'd8192;
        2:       pitch_word = 32'd16383;
        3:       pitch_word = 32'($urandom_range(0, 16383));
        default: pitch_word = $urandom;
      endcase
      write_reg(REG_BLOCK_FORMAT, fmt_word);
      write_reg(REG_ROW_PITCH, pitch_word);
      write_reg(REG_SWIZZLE_WORD, $urandom);
      // the spare index must leave every register alone
      if (p % 2 == 0) write_reg(REG_SPARE, $urandom);
      setting_count++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 9);
        cx = pick_coord(kind, kind == 8);
        cy = pick_coord(kind, kind == 9);
        send_coord(cx, cy, 1'b0, '0);
        random_count++;
      end
    end

    drain_offsets();
    if (pending_offsets.size() != 0)
      report_mismatch("offsets left pending", '0, '0);

    $display("ran %0d directed and %0d random coordinates over %0d register settings,",
             directed_count, random_count, setting_count);
    $display("all four format codes, pitch and coordinate extremes; %0d offsets checked",
             checked_count);
    if (error_count == 0) begin
      $display("macro_tiled_surface_address regression: pass");
    end else begin
      $display("macro_tiled_surface_address regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mtsa_pkg.sv
src/mtsa_datapath.sv
src/macro_tiled_surface_address.sv
src/mtsa_checker.sv
test/macro_tiled_surface_address_tb.sv
